### sv/assert_macros.svh
// Assertion helpers for the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define CHK_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Two signals never high together.
`define CHK_NEVER_BOTH(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

### sv/mlp_pkg.sv
package mlp_pkg;

	localparam int ValueW = 24;
	localparam int ActW   = 16;

	typedef enum logic [1:0] {
		FUNC_WEIGHT = 2'd0,
		FUNC_INPUT  = 2'd1,
		FUNC_EVAL   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_INPUTS  = 2'd0,
		CFG_HIDDEN  = 2'd1,
		CFG_NEURONS = 2'd2,
		CFG_OUTPUTS = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_BIAS,
		ST_SUM,
		ST_SIG,
		ST_STORE
	} state_t;

	function automatic logic [15:0] sig_knot(input logic [4:0] i);
		logic [15:0] r;
		begin
			case (i)
				5'd0:  r = 16'd32768;
				5'd1:  r = 16'd40793;
				5'd2:  r = 16'd47911;
				5'd3:  r = 16'd53581;
				5'd4:  r = 16'd57724;
				5'd5:  r = 16'd60564;
				5'd6:  r = 16'd62428;
				5'd7:  r = 16'd63615;
				5'd8:  r = 16'd64357;
				5'd9:  r = 16'd64809;
				5'd10: r = 16'd65097;
				5'd11: r = 16'd65269;
				5'd12: r = 16'd65374;
				5'd13: r = 16'd65438;
				5'd14: r = 16'd65476;
				5'd15: r = 16'd65500;
				5'd16: r = 16'd65514;
				default: r = 16'd65535;
			endcase
			return r;
		end
	endfunction

endpackage

### sv/mlp_sigmoid_inference_unit.sv
// Write items (weight, net input): acknowledge strobed the next cycle.
// Evaluate: per neuron, one weight read and one multiply-accumulate per cycle
// over its sources through the single weight memory read port, then bias,
// sum, sigmoid and store steps.
// busy is high while an evaluation runs; results cannot be stalled.
// arst_n clears control, registers and the net input and activation stores.
module mlp_sigmoid_inference_unit import mlp_pkg::*; #(
	parameter int MAX_INPUTS   = 16,
	parameter int MAX_NEURONS  = 16,
	parameter int MAX_HIDDEN   = 4,
	parameter int MAX_OUTPUTS  = 16,
	parameter int WEIGHT_DEPTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [10:0]        slot,
	input  logic signed [23:0] value,
	output logic               strobe,
	output logic               kind,
	output logic [3:0]         out_index,
	output logic [15:0]        activation,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	localparam int AW = $clog2(WEIGHT_DEPTH);
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int OUT_LIM = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;
	localparam int HW = 4;

	logic signed [23:0] wmem [WEIGHT_DEPTH];
	logic signed [23:0] nin_q [MAX_INPUTS];
	logic [15:0] abuf_q [2][MAX_NEURONS];

	logic [4:0] in_cnt_q, nph_q, out_cnt_q;
	logic [2:0] hid_q;

	state_t st_q, st_d;
	logic [AW-1:0] addr_q;
	logic [HW-1:0] layer_q;
	logic [4:0] nidx_q, src_q;
	logic signed [55:0] acc_q;
	logic signed [23:0] rd_s1;
	logic signed [23:0] x_s1;
	logic mac_s1;
	logic signed [47:0] prod_s2;
	logic prod_v_s2;
	logic [15:0] sig_q;

	// layer context
	logic is_out, from_in, dst;
	logic [4:0] srcn, ncnt;
	assign is_out  = (layer_q == HW'(hid_q));
	assign from_in = (layer_q == '0);
	assign srcn    = from_in ? in_cnt_q : nph_q;
	assign ncnt    = is_out ? out_cnt_q : nph_q;
	assign dst     = layer_q[0];

	function automatic logic [4:0] clampv(input logic [4:0] v, input int lo, input int hi);
		if (int'(v) < lo) return 5'(lo);
		if (int'(v) > hi) return 5'(hi);
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= 5'd1;
			hid_q     <= 3'd0;
			nph_q     <= 5'd1;
			out_cnt_q <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INPUTS:  in_cnt_q  <= clampv(cfg_data, 1, MAX_INPUTS);
				CFG_HIDDEN:  hid_q     <= 3'(clampv({2'b0, cfg_data[2:0]}, 0, MAX_HIDDEN));
				CFG_NEURONS: nph_q     <= clampv(cfg_data, 1, MAX_NEURONS);
				CFG_OUTPUTS: out_cnt_q <= clampv(cfg_data, 1, OUT_LIM);
				default: ;
			endcase
		end
	end

	logic accept;
	assign accept = start && !busy;
	assign busy = (st_q != ST_IDLE);

	// weight memory: write port for loads, registered read port for evaluation
	always_ff @(posedge clk) begin
		if (accept && func_t'(func) == FUNC_WEIGHT && 32'(slot) < WEIGHT_DEPTH)
			wmem[AW'(slot)] <= value;
		rd_s1 <= wmem[addr_q];
	end

	logic mac_go;
	assign mac_go = (st_q == ST_MAC) && (src_q < srcn);

	always_ff @(posedge clk) begin
		x_s1 <= from_in ? nin_q[IW'(src_q)]
			: 24'($unsigned(abuf_q[~dst][NW'(src_q)]));
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (accept && func_t'(func) == FUNC_EVAL) st_d = ST_MAC;
			ST_MAC:   if (!(src_q < srcn)) st_d = ST_BIAS;
			ST_BIAS:  st_d = ST_SUM;
			ST_SUM:   if (!prod_v_s2 && !mac_s1) st_d = ST_SIG;
			ST_SIG:   st_d = ST_STORE;
			ST_STORE: begin
				if (5'(nidx_q + 5'd1) < ncnt) st_d = ST_MAC;
				else if (is_out) st_d = ST_IDLE;
				else st_d = ST_MAC;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// sigmoid of floored sum
	logic signed [39:0] s_v;
	logic [39:0] m_v;
	logic [4:0] ki;
	logic [14:0] fr;
	logic [15:0] t0, t1;
	logic [31:0] dfr;
	logic [15:0] f_v;
	always_comb begin
		s_v = 40'(acc_q >>> 16);
		m_v = s_v[39] ? 40'(-s_v) : 40'(s_v);
		ki  = 5'(m_v[19:15]);
		fr  = m_v[14:0];
		t0  = sig_knot(ki);
		t1  = sig_knot(5'(ki + 5'd1));
		dfr = 32'(t1 - t0) * 32'(fr);
		if (m_v >= 40'(16 << 15)) f_v = 16'd65535;
		else f_v = 16'(t0 + 16'(dfr >> 15));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			addr_q    <= '0;
			layer_q   <= '0;
			nidx_q    <= '0;
			src_q     <= '0;
			acc_q     <= '0;
			mac_s1    <= 1'b0;
			prod_s2   <= '0;
			prod_v_s2 <= 1'b0;
			strobe    <= 1'b0;
			kind      <= 1'b0;
			out_index <= '0;
			activation <= '0;
			last      <= 1'b0;
			sig_q     <= '0;
			for (int i = 0; i < MAX_INPUTS; i++) nin_q[i] <= '0;
			for (int b = 0; b < 2; b++)
				for (int i = 0; i < MAX_NEURONS; i++) abuf_q[b][i] <= '0;
		end else begin
			st_q      <= st_d;
			strobe    <= 1'b0;
			mac_s1    <= mac_go;
			prod_v_s2 <= mac_s1;
			prod_s2   <= rd_s1 * x_s1;
			if (prod_v_s2) acc_q <= acc_q + 56'(prod_s2);
			if (accept) begin
				case (func_t'(func))
					FUNC_WEIGHT, FUNC_INPUT: begin
						if (func_t'(func) == FUNC_INPUT && 32'(slot) < MAX_INPUTS)
							nin_q[IW'(slot)] <= value;
						strobe <= 1'b1; kind <= 1'b0; out_index <= '0;
						activation <= '0; last <= 1'b1;
					end
					FUNC_EVAL: begin
						addr_q <= '0; layer_q <= '0; nidx_q <= '0;
						src_q <= '0; acc_q <= '0;
					end
					default: ;
				endcase
			end
			case (st_q)
				ST_MAC: if (mac_go) begin
					addr_q <= addr_q + 1'b1;
					src_q  <= src_q + 5'd1;
				end
				// bias read issued in the last MAC cycle and held here
				ST_BIAS: addr_q <= addr_q + 1'b1;
				ST_SUM: if (!prod_v_s2 && !mac_s1)
					acc_q <= acc_q - (56'(rd_s1) <<< 16);
				ST_SIG: sig_q <= s_v[39] ? 16'(17'd65536 - 17'(f_v)) : f_v;
				ST_STORE: begin
					acc_q <= '0; src_q <= '0;
					if (is_out) begin
						strobe <= 1'b1; kind <= 1'b1;
						out_index <= nidx_q[3:0]; activation <= sig_q;
						last <= (5'(nidx_q + 5'd1) == ncnt);
					end else begin
						abuf_q[dst][NW'(nidx_q)] <= sig_q;
					end
					if (5'(nidx_q + 5'd1) < ncnt) nidx_q <= nidx_q + 5'd1;
					else begin
						nidx_q <= '0;
						layer_q <= layer_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### sv/mlp_chk.sv
`include "assert_macros.svh"
module mlp_chk (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic strobe,
	input logic kind,
	input logic last,
	input logic [15:0] activation
);
	`CHK_PROP(ack_last, clk, arst_n, (strobe && !kind) |-> last, "ack without last")
	`CHK_PROP(ack_zero, clk, arst_n, (strobe && !kind) |-> (activation == 16'd0), "ack nonzero")
	`CHK_PROP(out_busy, clk, arst_n, (strobe && kind && !last) |-> busy, "output while idle")
endmodule

bind mlp_sigmoid_inference_unit mlp_chk u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy), .strobe(strobe),
	.kind(kind), .last(last), .activation(activation)
);
